// File: hdl/ssl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg
// shared constants, types and sigmoid table of the stochastic synapse learner
// ----------------------------------------------------------------------------
package ssl_pkg;

  localparam int MAX_SPIKES      = 1024;
  localparam int MAX_TRIALS      = 1024;
  localparam int SIGMOID_ENTRIES = 256;

  localparam int SPK_W = $clog2(MAX_SPIKES + 1);
  localparam int TRL_W = $clog2(MAX_TRIALS + 1);
  localparam int DVS_W = (SPK_W > TRL_W) ? SPK_W : TRL_W;

  // accumulator widths
  localparam int TP_W    = 18 + SPK_W - 1;
  localparam int PSUM_W  = 18 + TRL_W - 1;
  localparam int PSQ_W   = 33 + TRL_W - 1;
  localparam int CORR_W  = 42 + TRL_W - 1;
  localparam int ESUM_W  = 24 + TRL_W;
  localparam int DVD_W   = (CORR_W > TP_W) ? CORR_W : TP_W;
  localparam int CHKA_W  = TRL_W + PSQ_W;
  localparam int CHKB_W  = 2 * PSUM_W;
  localparam int CHK_W   = (CHKA_W > CHKB_W) ? CHKA_W : CHKB_W;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int SIG_IDX_W  = $clog2(SIGMOID_ENTRIES);
  localparam int SIG_STEP   = 32768 / SIGMOID_ENTRIES;

  localparam logic [15:0] LEARN_RATE_RST   = 16'd655;
  localparam logic [15:0] DECAY_RST        = 16'd0;
  localparam logic [31:0] SEED_A_RST       = 32'd12345;
  localparam logic [31:0] SEED_B_RST       = 32'd23456;
  localparam logic [31:0] SEED_C_RST       = 32'd34567;
  localparam logic [31:0] SEED_LCG_RST     = 32'd45678;
  localparam logic signed [15:0] LOGIT_RST = 16'sd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LEARN_RATE  = 3'd0,
    CFG_DECAY       = 3'd1,
    CFG_SEED_A      = 3'd2,
    CFG_SEED_B      = 3'd3,
    CFG_SEED_C      = 3'd4,
    CFG_SEED_LCG    = 3'd5,
    CFG_START_LOGIT = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SPIKE  = 2'd0,
    OP_RECORD = 2'd1,
    OP_UPDATE = 2'd2,
    OP_IDLE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    COMMIT_NONE  = 3'd0,
    COMMIT_SPIKE = 3'd1,
    COMMIT_REC   = 3'd2,
    COMMIT_UPD   = 3'd3,
    COMMIT_NOP   = 3'd4
  } commit_e;

  typedef enum logic [1:0] {
    DIV_TRIAL = 2'd0,
    DIV_CORR  = 2'd1,
    DIV_ERR   = 2'd2,
    DIV_PERT  = 2'd3
  } div_src_e;

  typedef struct packed {
    logic     accept;
    commit_e  commit;
    logic     apply;
    logic     div_start;
    div_src_e div_src;
    logic     ld_avg;
    logic     rec_mul;
    logic     upd_chk;
    logic     ld_avcorr;
    logic     ld_averr;
    logic     ld_avpert;
    logic     upd_mul1;
    logic     upd_inner;
    logic     upd_mul2;
    logic     upd_step;
  } ssl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic upd_go;
  } ssl_status_t;

  typedef logic [15:0] sig_tab_t [SIGMOID_ENTRIES];

  // truncated q.62 product
  function automatic logic [63:0] mulq62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic logic [16:0] sig_pos(input logic [15:0] t);
    logic [63:0]  ec [16];
    logic [63:0]  e;
    logic [63:0]  den;
    logic [62:0]  num;
    logic [64:0]  rem;
    logic [62:0]  quo;
    ec[0] = (64'd1 << 62) - (64'd1 << 50) + (64'd1 << 37) - 64'd2796203 + 64'd171;
    for (int k = 1; k < 16; k++) begin
      ec[k] = mulq62(ec[k-1], ec[k-1]);
    end
    e = 64'd1 << 62;
    for (int k = 0; k < 16; k++) begin
      if (t[k]) begin
        e = mulq62(e, ec[k]);
      end
    end
    den = (64'd1 << 46) + (e >> 16);
    num = 63'((64'd1 << 62) + (den >> 1));
    rem = '0;
    quo = '0;
    // round(num/den) by shift and subtract
    for (int i = 62; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo[16:0];
  endfunction

  function automatic sig_tab_t build_sig_tab();
    sig_tab_t   tab;
    int         x;
    logic [16:0] p;
    for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
      x = (2 * i + 1) * SIG_STEP - 32768;
      if (x >= 0) begin
        p = sig_pos(16'(x));
      end else begin
        p = 17'd65536 - sig_pos(16'(-x));
      end
      tab[i] = (p > 17'd65535) ? 16'hFFFF : p[15:0];
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TAB = build_sig_tab();

  function automatic logic [15:0] sig_lookup(input logic [15:0] q);
    logic [15:0] u;
    u = {~q[15], q[14:0]};
    return SIG_TAB[u[15 -: SIG_IDX_W]];
  endfunction

  localparam logic [15:0] PROB_RST = sig_lookup(LOGIT_RST);

endpackage

// File: hdl/ssl_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_in_if / ssl_out_if
// valid/ready channels carrying operations in and results out
// ----------------------------------------------------------------------------
interface ssl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic               spike_in;
  logic signed [23:0] error_value;

  modport source (output valid, output operation, output spike_in, output error_value,
                  input ready);
  modport sink   (input valid, input operation, input spike_in, input error_value,
                  output ready);
endinterface

interface ssl_out_if;
  logic               valid;
  logic               ready;
  logic               released;
  logic [15:0]        release_prob;
  logic signed [15:0] logit_now;
  logic               adjusted;

  modport source (output valid, output released, output release_prob, output logit_now,
                  output adjusted, input ready);
  modport sink   (input valid, input released, input release_prob, input logit_now,
                  input adjusted, output ready);
endinterface

// File: hdl/ssl_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_div
// signed by unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module ssl_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic signed [ssl_pkg::DVD_W-1:0] dividend_i,
  input  logic [ssl_pkg::DVS_W-1:0]        divisor_i,
  output logic signed [ssl_pkg::DVD_W-1:0] quotient_o,
  output logic                             done_o
);

  localparam int CNT_W = $clog2(ssl_pkg::DVD_W);

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic [ssl_pkg::DVD_W-1:0]  work_q, work_d;
  logic [ssl_pkg::DVS_W:0]    rem_q, rem_d;
  logic [ssl_pkg::DVS_W-1:0]  dvs_q, dvs_d;
  logic                       neg_q, neg_d;
  logic [ssl_pkg::DVS_W:0]    rem_sh;
  logic                       ge;

  assign rem_sh = {rem_q[ssl_pkg::DVS_W-1:0], work_q[ssl_pkg::DVD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    work_d = work_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      neg_d  = dividend_i[ssl_pkg::DVD_W-1];
      work_d = neg_d ? ssl_pkg::DVD_W'(-dividend_i) : dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = ge ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      work_d = {work_q[ssl_pkg::DVD_W-2:0], ge};
      if (cnt_q == CNT_W'(ssl_pkg::DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    work_q <= work_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
  end

  assign quotient_o = neg_q ? -$signed(work_q) : $signed(work_q);
  assign done_o     = done_q;

endmodule

// File: hdl/ssl_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_dpath
// generator, learning sums, update arithmetic and result register
// ----------------------------------------------------------------------------
module ssl_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssl_pkg::ssl_cmd_t                   cmd_i,
  output ssl_pkg::ssl_status_t                status_o,
  input  logic                                spike_in_i,
  input  logic signed [23:0]                  error_value_i,
  input  logic                                cfg_we_i,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  output logic                                released_o,
  output logic [15:0]                         release_prob_o,
  output logic signed [15:0]                  logit_now_o,
  output logic                                adjusted_o
);

  function automatic logic [31:0] taus(input logic [31:0] z, input int unsigned s1,
                                       input int unsigned s2, input int unsigned s3,
                                       input logic [31:0] m);
    logic [31:0] b;
    b = ((z << s1) ^ z) >> s2;
    return ((z & m) << s3) ^ b;
  endfunction

  // architectural state
  logic [15:0]                        lr_q, decay_q;
  logic [31:0]                        rng_a_q, rng_b_q, rng_c_q, rng_d_q;
  logic signed [15:0]                 logit_q;
  logic [15:0]                        prob_q;
  logic signed [ssl_pkg::TP_W-1:0]    trial_pert_q;
  logic [ssl_pkg::SPK_W-1:0]          trial_spk_q;
  logic signed [ssl_pkg::PSUM_W-1:0]  pert_sum_q;
  logic [ssl_pkg::PSQ_W-1:0]          pertsq_q;
  logic signed [ssl_pkg::CORR_W-1:0]  corr_q;
  logic signed [ssl_pkg::ESUM_W-1:0]  err_sum_q;
  logic [ssl_pkg::TRL_W-1:0]          trial_tot_q;

  // scratch
  logic                               spike_q;
  logic signed [23:0]                 err_q;
  logic signed [17:0]                 avg_q;
  logic [32:0]                        avg_sq_q;
  logic signed [41:0]                 avg_err_q;
  logic [ssl_pkg::CHK_W-1:0]          chk_a_q, chk_b_q;
  logic signed [40:0]                 avcorr_q;
  logic signed [23:0]                 averr_q;
  logic signed [17:0]                 avpert_q;
  logic signed [41:0]                 m1_q;
  logic [31:0]                        m2_q;
  logic signed [41:0]                 inner_q;
  logic [36:0]                        plo_q;
  logic signed [36:0]                 phi_q;
  logic signed [15:0]                 new_logit_q;

  // result register
  logic                               rel_q, adj_q;
  logic [15:0]                        oprob_q;
  logic signed [15:0]                 ologit_q;

  // divider
  logic signed [ssl_pkg::DVD_W-1:0]   dvd;
  logic [ssl_pkg::DVS_W-1:0]          dvs;
  logic signed [ssl_pkg::DVD_W-1:0]   quo;
  logic                               div_done;

  always_comb begin
    case (cmd_i.div_src)
      ssl_pkg::DIV_TRIAL: begin
        dvd = ssl_pkg::DVD_W'(trial_pert_q);
        dvs = ssl_pkg::DVS_W'(trial_spk_q);
      end
      ssl_pkg::DIV_CORR: begin
        dvd = ssl_pkg::DVD_W'(corr_q);
        dvs = ssl_pkg::DVS_W'(trial_tot_q);
      end
      ssl_pkg::DIV_ERR: begin
        dvd = ssl_pkg::DVD_W'(err_sum_q);
        dvs = ssl_pkg::DVS_W'(trial_tot_q);
      end
      default: begin
        dvd = ssl_pkg::DVD_W'(pert_sum_q);
        dvs = ssl_pkg::DVS_W'(trial_tot_q);
      end
    endcase
  end

  ssl_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dvd),
    .divisor_i  (dvs),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  // generator step
  logic [31:0] nxt_a, nxt_b, nxt_c, nxt_d, rnd;
  logic        go, spk_room;
  logic signed [17:0] delta;

  assign nxt_a = taus(rng_a_q, 13, 19, 12, 32'hFFFF_FFFE);
  assign nxt_b = taus(rng_b_q, 2, 25, 4, 32'hFFFF_FFF8);
  assign nxt_c = taus(rng_c_q, 3, 11, 17, 32'hFFFF_FFF0);
  assign nxt_d = rng_d_q * 32'd1664525 + 32'd1013904223;
  assign rnd   = nxt_a ^ nxt_b ^ nxt_c ^ nxt_d;
  assign go    = (rnd[31:16] < prob_q);
  assign spk_room = (trial_spk_q < ssl_pkg::SPK_W'(ssl_pkg::MAX_SPIKES));
  assign delta = go ? (18'sd65536 - $signed({2'b00, prob_q})) : -$signed({2'b00, prob_q});

  // update arithmetic
  logic [ssl_pkg::PSUM_W-1:0] pert_abs;
  logic signed [57:0]         prod;
  logic signed [21:0]         step;
  logic signed [22:0]         qsum;
  logic signed [15:0]         qclamp;
  logic signed [15:0]         logit_fin;

  assign pert_abs = pert_sum_q[ssl_pkg::PSUM_W-1] ? ssl_pkg::PSUM_W'(-pert_sum_q)
                                                   : pert_sum_q;
  assign prod   = (58'(phi_q) <<< 21) + $signed(58'(plo_q));
  assign step   = prod[57:36];
  assign qsum   = 23'(logit_q) + 23'(step);
  assign qclamp = (qsum < -23'sd32768) ? -16'sd32768 :
                  (qsum > 23'sd32767)  ? 16'sd32767  : qsum[15:0];
  assign logit_fin = cmd_i.apply ? new_logit_q : logit_q;

  logic trl_room;
  assign trl_room = (trial_tot_q < ssl_pkg::TRL_W'(ssl_pkg::MAX_TRIALS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lr_q         <= ssl_pkg::LEARN_RATE_RST;
      decay_q      <= ssl_pkg::DECAY_RST;
      rng_a_q      <= ssl_pkg::SEED_A_RST;
      rng_b_q      <= ssl_pkg::SEED_B_RST;
      rng_c_q      <= ssl_pkg::SEED_C_RST;
      rng_d_q      <= ssl_pkg::SEED_LCG_RST;
      logit_q      <= ssl_pkg::LOGIT_RST;
      prob_q       <= ssl_pkg::PROB_RST;
      trial_pert_q <= '0;
      trial_spk_q  <= '0;
      pert_sum_q   <= '0;
      pertsq_q     <= '0;
      corr_q       <= '0;
      err_sum_q    <= '0;
      trial_tot_q  <= '0;
    end else begin
      case (cmd_i.commit)
        ssl_pkg::COMMIT_SPIKE: begin
          rng_a_q <= nxt_a;
          rng_b_q <= nxt_b;
          rng_c_q <= nxt_c;
          rng_d_q <= nxt_d;
          if (spike_q && spk_room) begin
            trial_pert_q <= trial_pert_q + ssl_pkg::TP_W'(delta);
            trial_spk_q  <= trial_spk_q + 1'b1;
          end
        end
        ssl_pkg::COMMIT_REC: begin
          if (trl_room) begin
            if (trial_spk_q != '0) begin
              pert_sum_q <= pert_sum_q + ssl_pkg::PSUM_W'(avg_q);
              pertsq_q   <= pertsq_q + ssl_pkg::PSQ_W'(avg_sq_q);
              corr_q     <= corr_q + ssl_pkg::CORR_W'(avg_err_q);
              err_sum_q  <= err_sum_q + ssl_pkg::ESUM_W'(err_q);
            end
            trial_tot_q <= trial_tot_q + 1'b1;
          end
          trial_pert_q <= '0;
          trial_spk_q  <= '0;
        end
        ssl_pkg::COMMIT_UPD: begin
          logit_q      <= logit_fin;
          prob_q       <= ssl_pkg::sig_lookup(logit_fin);
          trial_pert_q <= '0;
          trial_spk_q  <= '0;
          pert_sum_q   <= '0;
          pertsq_q     <= '0;
          corr_q       <= '0;
          err_sum_q    <= '0;
          trial_tot_q  <= '0;
        end
        default: begin
        end
      endcase
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ssl_pkg::CFG_LEARN_RATE:  lr_q    <= cfg_data_i[15:0];
          ssl_pkg::CFG_DECAY:       decay_q <= cfg_data_i[15:0];
          ssl_pkg::CFG_SEED_A:      rng_a_q <= cfg_data_i;
          ssl_pkg::CFG_SEED_B:      rng_b_q <= cfg_data_i;
          ssl_pkg::CFG_SEED_C:      rng_c_q <= cfg_data_i;
          ssl_pkg::CFG_SEED_LCG:    rng_d_q <= cfg_data_i;
          ssl_pkg::CFG_START_LOGIT: begin
            logit_q <= cfg_data_i[15:0];
            prob_q  <= ssl_pkg::sig_lookup(cfg_data_i[15:0]);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      spike_q <= spike_in_i;
      err_q   <= error_value_i;
    end
    if (cmd_i.ld_avg) begin
      avg_q <= quo[17:0];
    end
    if (cmd_i.rec_mul) begin
      avg_sq_q  <= 33'(avg_q * avg_q);
      avg_err_q <= 42'(avg_q * err_q);
    end
    if (cmd_i.upd_chk) begin
      chk_a_q <= ssl_pkg::CHK_W'(trial_tot_q * pertsq_q);
      chk_b_q <= ssl_pkg::CHK_W'(pert_abs * pert_abs);
    end
    if (cmd_i.ld_avcorr) begin
      avcorr_q <= quo[40:0];
    end
    if (cmd_i.ld_averr) begin
      averr_q <= quo[23:0];
    end
    if (cmd_i.ld_avpert) begin
      avpert_q <= quo[17:0];
    end
    if (cmd_i.upd_mul1) begin
      m1_q <= 42'(averr_q * avpert_q);
      m2_q <= decay_q * prob_q;
    end
    if (cmd_i.upd_inner) begin
      inner_q <= 42'(avcorr_q) - m1_q - $signed({10'd0, m2_q});
    end
    if (cmd_i.upd_mul2) begin
      plo_q <= lr_q * inner_q[20:0];
      phi_q <= 37'($signed({1'b0, lr_q}) * $signed(inner_q[41:21]));
    end
    if (cmd_i.upd_step) begin
      new_logit_q <= qclamp;
    end
    // result register
    case (cmd_i.commit)
      ssl_pkg::COMMIT_SPIKE: begin
        rel_q    <= spike_q & go;
        adj_q    <= 1'b0;
        oprob_q  <= prob_q;
        ologit_q <= logit_q;
      end
      ssl_pkg::COMMIT_UPD: begin
        rel_q    <= 1'b0;
        adj_q    <= cmd_i.apply && (new_logit_q != logit_q);
        oprob_q  <= ssl_pkg::sig_lookup(logit_fin);
        ologit_q <= logit_fin;
      end
      ssl_pkg::COMMIT_REC, ssl_pkg::COMMIT_NOP: begin
        rel_q    <= 1'b0;
        adj_q    <= 1'b0;
        oprob_q  <= prob_q;
        ologit_q <= logit_q;
      end
      default: begin
      end
    endcase
  end

  assign status_o.div_done = div_done;
  assign status_o.upd_go   = (trial_tot_q != '0) && (chk_a_q != chk_b_q);

  assign released_o     = rel_q;
  assign release_prob_o = oprob_q;
  assign logit_now_o    = ologit_q;
  assign adjusted_o     = adj_q;

endmodule

// File: hdl/ssl_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_ctrl
// operation sequencer and result-valid flag
// ----------------------------------------------------------------------------
module ssl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic [1:0]            in_op_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output ssl_pkg::ssl_cmd_t     cmd_o,
  input  ssl_pkg::ssl_status_t  status_i
);

  typedef enum logic [15:0] {
    S_IDLE       = 16'h0001,
    S_SPIKE      = 16'h0002,
    S_NOP        = 16'h0004,
    S_REC_DIV    = 16'h0008,
    S_REC_MUL    = 16'h0010,
    S_REC_COMMIT = 16'h0020,
    S_UPD_CHK    = 16'h0040,
    S_UPD_CMP    = 16'h0080,
    S_DIV_CORR   = 16'h0100,
    S_DIV_ERR    = 16'h0200,
    S_DIV_PERT   = 16'h0400,
    S_UPD_MUL1   = 16'h0800,
    S_UPD_INNER  = 16'h1000,
    S_UPD_MUL2   = 16'h2000,
    S_UPD_STEP   = 16'h4000,
    S_UPD_COMMIT = 16'h8000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   apply_q, apply_d;
  logic   out_free;
  logic   accept;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    apply_d = apply_q;
    cmd_o   = '0;
    cmd_o.accept = accept;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_op_i)
            ssl_pkg::OP_SPIKE:  state_d = S_SPIKE;
            ssl_pkg::OP_RECORD: begin
              cmd_o.div_start = 1'b1;
              cmd_o.div_src   = ssl_pkg::DIV_TRIAL;
              state_d         = S_REC_DIV;
            end
            ssl_pkg::OP_UPDATE: state_d = S_UPD_CHK;
            default:            state_d = S_NOP;
          endcase
        end
      end
      S_SPIKE: begin
        if (out_free) begin
          cmd_o.commit = ssl_pkg::COMMIT_SPIKE;
          state_d      = S_IDLE;
        end
      end
      S_NOP: begin
        if (out_free) begin
          cmd_o.commit = ssl_pkg::COMMIT_NOP;
          state_d      = S_IDLE;
        end
      end
      S_REC_DIV: begin
        if (status_i.div_done) begin
          cmd_o.ld_avg = 1'b1;
          state_d      = S_REC_MUL;
        end
      end
      S_REC_MUL: begin
        cmd_o.rec_mul = 1'b1;
        state_d       = S_REC_COMMIT;
      end
      S_REC_COMMIT: begin
        if (out_free) begin
          cmd_o.commit = ssl_pkg::COMMIT_REC;
          state_d      = S_IDLE;
        end
      end
      S_UPD_CHK: begin
        cmd_o.upd_chk = 1'b1;
        state_d       = S_UPD_CMP;
      end
      S_UPD_CMP: begin
        // skip the step on an empty epoch or zero variance
        apply_d = status_i.upd_go;
        if (status_i.upd_go) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = ssl_pkg::DIV_CORR;
          state_d         = S_DIV_CORR;
        end else begin
          state_d = S_UPD_COMMIT;
        end
      end
      S_DIV_CORR: begin
        if (status_i.div_done) begin
          cmd_o.ld_avcorr = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = ssl_pkg::DIV_ERR;
          state_d         = S_DIV_ERR;
        end
      end
      S_DIV_ERR: begin
        if (status_i.div_done) begin
          cmd_o.ld_averr  = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_src   = ssl_pkg::DIV_PERT;
          state_d         = S_DIV_PERT;
        end
      end
      S_DIV_PERT: begin
        if (status_i.div_done) begin
          cmd_o.ld_avpert = 1'b1;
          state_d         = S_UPD_MUL1;
        end
      end
      S_UPD_MUL1: begin
        cmd_o.upd_mul1 = 1'b1;
        state_d        = S_UPD_INNER;
      end
      S_UPD_INNER: begin
        cmd_o.upd_inner = 1'b1;
        state_d         = S_UPD_MUL2;
      end
      S_UPD_MUL2: begin
        cmd_o.upd_mul2 = 1'b1;
        state_d        = S_UPD_STEP;
      end
      S_UPD_STEP: begin
        cmd_o.upd_step = 1'b1;
        state_d        = S_UPD_COMMIT;
      end
      S_UPD_COMMIT: begin
        cmd_o.apply = apply_q;
        if (out_free) begin
          cmd_o.commit = ssl_pkg::COMMIT_UPD;
          state_d      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.commit != ssl_pkg::COMMIT_NONE) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      apply_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      apply_q     <= apply_d;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_commit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.commit != ssl_pkg::COMMIT_NONE) |-> (!out_valid_q || out_ready_i))
    else $error("result committed over an untaken result");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q != S_IDLE))
    else $error("accepted operation not started");

  a_div_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == S_REC_DIV || state_q == S_DIV_CORR ||
                           state_q == S_DIV_ERR || state_q == S_DIV_PERT))
    else $error("divider finished outside a wait state");
`endif

endmodule

// File: hdl/stochastic_synapse_learner_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stochastic_synapse_learner_top
// stochastic synapse with perturbation-correlation learning of its release
// ----------------------------------------------------------------------------
// usage
//   in_i carries one operation per transfer (spike, record error, update,
//   idle); out_o returns exactly one result per operation, in order.
//   configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) are registered in
//   the datapath; write them only while no operation is in flight.
// sequencing
//   spike and idle: the generator step plus the result load; the next
//   operation is taken only after this one commits, which out_o can stall.
//   record error: the 52-step serial divider forms the trial average, then
//   the square and error products are formed and the sums commit.
//   update: three serial divisions for the epoch averages with nonzero
//   variance; only the check, compare and commit when the step is skipped.
// reset
//   generators load the default seeds, logit loads the default start logit,
//   probability loads its sigmoid entry, every sum and count clears.
// stall
//   a finished result waits in the output register; the next operation is
//   still taken and runs up to its commit, then holds until out_o drains.
// ----------------------------------------------------------------------------
module stochastic_synapse_learner_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ssl_in_if.sink                            in_i,
  ssl_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [ssl_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [ssl_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // controller/datapath link
  ssl_pkg::ssl_cmd_t    cmd;
  ssl_pkg::ssl_status_t status;

  ssl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_op_i     (in_i.operation),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // generator, sums, divider and the result register
  ssl_dpath u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .spike_in_i     (in_i.spike_in),
    .error_value_i  (in_i.error_value),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .released_o     (out_o.released),
    .release_prob_o (out_o.release_prob),
    .logit_now_o    (out_o.logit_now),
    .adjusted_o     (out_o.adjusted)
  );

endmodule
